// ----- design/k_mismatch_first_match_finder_defines.svh -----
// Assertion macros for the k-mismatch first match finder.
// Included by the top level; relies on ports named clock and reset.
`ifndef K_MISMATCH_FIRST_MATCH_FINDER_DEFINES_SVH
`define K_MISMATCH_FIRST_MATCH_FINDER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KMM_ASSERT_IMPLY(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define KMM_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- design/kmm_pkg.sv -----
// Shared constants and types of the k-mismatch first match finder.
// Used by the queue, front, back and top-level modules; no dependencies.
`default_nettype none

package kmm_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int MAX_TEXT    = 4096;

   localparam int BYTE_W      = 8;
   localparam int SEEN_W      = $clog2(MAX_TEXT + 1);
   localparam int OFFSET_W    = 12;
   localparam int LEN_W       = 5;
   localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
   localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MISMATCH = CSR_IDX_W'(3);

   typedef struct packed {
      logic [CSR_DATA_W-1:0] pattern_low_bytes;
      logic [CSR_DATA_W-1:0] pattern_high_bytes;
      logic [LEN_W-1:0]      pattern_length;
      logic [LEN_W-1:0]      max_mismatch;
   } cfg_type;

   // One classified text byte on its way from the front to the back.
   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              last_byte;
      logic              store;
      logic [SEEN_W-1:0] pos;
   } item_type;

   typedef struct packed {
      logic              valid;
      logic              full;
      logic [QCNT_W-1:0] count;
   } qstat_type;

endpackage

`default_nettype wire

// ----- design/kmm_queue.sv -----
// Short item queue between the front and back of the k-mismatch finder.
// Depends on kmm_pkg for the item type and depth.
`default_nettype none

module kmm_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire kmm_pkg::item_type push_item,
   input  wire logic              pop,
   output kmm_pkg::item_type      head_item,
   output kmm_pkg::qstat_type     status
);

   kmm_pkg::item_type                entries_ff [kmm_pkg::QUEUE_DEPTH];
   logic [kmm_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [kmm_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [kmm_pkg::QCNT_W-1:0]       count_ff, count_in;

   function automatic logic [kmm_pkg::QPTR_W-1:0] next_ptr(
      input logic [kmm_pkg::QPTR_W-1:0] ptr
   );
      if (ptr == kmm_pkg::QPTR_W'(kmm_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + kmm_pkg::QPTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + kmm_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - kmm_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = entries_ff[rd_ptr_ff];
   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == kmm_pkg::QCNT_W'(kmm_pkg::QUEUE_DEPTH));
   assign status.count = count_ff;

endmodule

`default_nettype wire

// ----- design/kmm_front.sv -----
// Front of the k-mismatch finder: takes text bytes, counts them and marks
// which ones fall inside the text limit. Depends on kmm_pkg.
`default_nettype none

module kmm_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [kmm_pkg::BYTE_W-1:0]   req_text_byte,
   input  wire logic                         req_last_byte,
   input  wire kmm_pkg::qstat_type           q_status,
   output logic                              push,
   output kmm_pkg::item_type                 push_item
);

   logic [kmm_pkg::SEEN_W-1:0] seen_ff, seen_in;
   logic                       store;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;
   assign store     = (seen_ff < kmm_pkg::SEEN_W'(kmm_pkg::MAX_TEXT));

   always_comb begin
      push_item.text_byte = req_text_byte;
      push_item.last_byte = req_last_byte;
      push_item.store     = store;
      push_item.pos       = seen_ff + kmm_pkg::SEEN_W'(1);

      seen_in = seen_ff;
      if (push) begin
         if (req_last_byte) begin
            seen_in = '0;
         end else if (store) begin
            seen_in = seen_ff + kmm_pkg::SEEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/kmm_back.sv -----
// Back of the k-mismatch finder: shift window, parallel byte compare,
// mismatch count, first-hit latch and result register. Depends on kmm_pkg.
`default_nettype none

module kmm_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire kmm_pkg::cfg_type               cfg,
   input  wire kmm_pkg::qstat_type             q_status,
   input  wire kmm_pkg::item_type              head_item,
   output logic                                pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_match_found,
   output logic [kmm_pkg::OFFSET_W-1:0]        rsp_match_offset
);

   logic [kmm_pkg::BYTE_W-1:0]   window_ff [kmm_pkg::MAX_PATTERN];
   logic [kmm_pkg::BYTE_W-1:0]   new_win   [kmm_pkg::MAX_PATTERN];
   logic                         hit_ff, hit_in;
   logic [kmm_pkg::OFFSET_W-1:0] hit_offset_ff, hit_offset_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         found_ff, found_in;
   logic [kmm_pkg::OFFSET_W-1:0] offset_ff, offset_in;

   logic [2*kmm_pkg::CSR_DATA_W-1:0] pattern_all;
   logic [kmm_pkg::LEN_W-1:0]        used_len;
   logic [kmm_pkg::MAX_PATTERN-1:0]  diff;
   logic [kmm_pkg::CNT_W-1:0]        diff_cnt;
   logic                             window_full;
   logic                             do_cmp;
   logic                             hit_now;
   logic                             hit_any;
   logic [kmm_pkg::OFFSET_W-1:0]     off_now;
   logic [kmm_pkg::OFFSET_W-1:0]     off_any;

   assign pattern_all = {cfg.pattern_high_bytes, cfg.pattern_low_bytes};
   assign used_len    = (cfg.pattern_length > kmm_pkg::LEN_W'(kmm_pkg::MAX_PATTERN))
                        ? kmm_pkg::LEN_W'(kmm_pkg::MAX_PATTERN) : cfg.pattern_length;

   // A last byte can only be taken once the output register is free this cycle.
   assign pop = q_status.valid && (!head_item.last_byte || !rsp_valid_ff || !rsp_stall);

   always_comb begin
      logic [kmm_pkg::LEN_W-1:0] idx;
      new_win[0] = head_item.text_byte;
      for (int j = 1; j < kmm_pkg::MAX_PATTERN; j++) begin
         new_win[j] = window_ff[j-1];
      end
      // Pattern byte k lines up with the window byte that is used_len-1-k old.
      for (int k = 0; k < kmm_pkg::MAX_PATTERN; k++) begin
         idx = used_len - kmm_pkg::LEN_W'(k) - kmm_pkg::LEN_W'(1);
         diff[k] = (kmm_pkg::LEN_W'(k) < used_len) &&
                   (new_win[idx[kmm_pkg::PAT_IDX_W-1:0]] != pattern_all[8*k +: 8]);
      end
   end

   assign diff_cnt    = kmm_pkg::CNT_W'($countones(diff));
   assign window_full = ({{(kmm_pkg::SEEN_W - kmm_pkg::LEN_W){1'b0}}, used_len}
                         <= head_item.pos);
   assign do_cmp      = pop && head_item.store && (used_len != '0) && window_full && !hit_ff;
   assign hit_now     = do_cmp &&
                        ({{(kmm_pkg::LEN_W - kmm_pkg::CNT_W){1'b0}}, diff_cnt}
                         <= cfg.max_mismatch);
   assign off_now     = kmm_pkg::OFFSET_W'(head_item.pos
                        - {{(kmm_pkg::SEEN_W - kmm_pkg::LEN_W){1'b0}}, used_len});
   assign hit_any     = hit_ff || hit_now;
   assign off_any     = hit_ff ? hit_offset_ff : off_now;

   always_comb begin
      hit_in        = hit_ff;
      hit_offset_in = hit_offset_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      found_in      = found_ff;
      offset_in     = offset_ff;
      if (hit_now) begin
         hit_in        = 1'b1;
         hit_offset_in = off_now;
      end
      if (pop && head_item.last_byte) begin
         rsp_valid_in = 1'b1;
         hit_in       = 1'b0;
         if (used_len == '0) begin
            // An empty pattern matches at the start of every text.
            found_in  = 1'b1;
            offset_in = '0;
         end else begin
            found_in  = hit_any;
            offset_in = hit_any ? off_any : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_offset_ff <= hit_offset_in;
      found_ff      <= found_in;
      offset_ff     <= offset_in;
      if (pop && head_item.store) begin
         for (int j = 0; j < kmm_pkg::MAX_PATTERN; j++) begin
            window_ff[j] <= new_win[j];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_found  = found_ff;
   assign rsp_match_offset = offset_ff;

endmodule

`default_nettype wire

// ----- design/k_mismatch_first_match_finder.sv -----
// Channel  Handshake             Payload
// req      req_valid/req_stall   req_text_byte[7:0], req_last_byte
// rsp      rsp_valid/rsp_stall   rsp_match_found, rsp_match_offset[11:0]
// csr      csr_valid/csr_ready   csr_index[7:0], csr_data[63:0]
//
// One text byte is taken per cycle while req_stall is low; the back compares
// the whole window combinationally on bytes registered in the two-entry queue.
// A result appears in the cycle after its last byte is taken by the back.
// Reset is synchronous and clears counters, the hit latch and the queue.
// A stalled result holds the back once a last byte is next; the queue then
// fills and req_stall rises after one more byte.
//
// Top level: configuration registers, front, queue and back.
// Depends on kmm_pkg, kmm_front, kmm_queue, kmm_back and the defines header.
`default_nettype none
`include "k_mismatch_first_match_finder_defines.svh"

module k_mismatch_first_match_finder (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [kmm_pkg::BYTE_W-1:0]       req_text_byte,
   input  wire logic                             req_last_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_match_found,
   output logic [kmm_pkg::OFFSET_W-1:0]          rsp_match_offset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [kmm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [kmm_pkg::CSR_DATA_W-1:0]   csr_data
);

   kmm_pkg::cfg_type   cfg_ff, cfg_in;
   kmm_pkg::qstat_type q_status;
   kmm_pkg::item_type  push_item;
   kmm_pkg::item_type  head_item;
   logic               push;
   logic               pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            kmm_pkg::CSR_PATTERN_LOW:  cfg_in.pattern_low_bytes  = csr_data;
            kmm_pkg::CSR_PATTERN_HIGH: cfg_in.pattern_high_bytes = csr_data;
            kmm_pkg::CSR_PATTERN_LEN:
               cfg_in.pattern_length = csr_data[kmm_pkg::LEN_W-1:0];
            kmm_pkg::CSR_MAX_MISMATCH:
               cfg_in.max_mismatch   = csr_data[kmm_pkg::LEN_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   kmm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .req_last_byte (req_last_byte),
      .q_status      (q_status),
      .push          (push),
      .push_item     (push_item)
   );

   kmm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status)
   );

   kmm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_status         (q_status),
      .head_item        (head_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_match_found  (rsp_match_found),
      .rsp_match_offset (rsp_match_offset)
   );

   `KMM_ASSERT_NEXT(a_last_gives_result, pop && head_item.last_byte, rsp_valid, "last item produced no result")
   `KMM_ASSERT_IMPLY(a_pop_nonempty, pop, q_status.count != '0, "pop from empty queue")
   `KMM_ASSERT_IMPLY(a_count_bound, 1'b1, q_status.count <= kmm_pkg::QCNT_W'(kmm_pkg::QUEUE_DEPTH), "queue count beyond depth")
   `KMM_ASSERT_IMPLY(a_miss_offset_zero, rsp_valid && !rsp_match_found, rsp_match_offset == '0, "nonzero offset without a match")

endmodule

`default_nettype wire
